// ===== hw/rtl/pcp_pkg.sv =====
// Shared types, constants and tables of the parametric curve point block.
package pcp_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned MidDepth        = 4;
  localparam int unsigned OutDepth        = 2;

  localparam logic [16:0] QOne      = 17'd65536;
  localparam logic [32:0] Deg90     = 33'd5898240;
  // 92 full turns: lifts any blended angle above zero, keeps quadrant phase
  localparam logic signed [51:0] AngleLift = 52'sd2170552320;
  // ceil(2^22 / 45): exact quotient for 16-bit numerators
  localparam logic [32:0] Recip45   = 33'd93207;
  localparam logic [57:0] Deg2Rad   = 58'd19190098069;
  localparam logic signed [32:0] CordicGain = 33'sd652032874;

  typedef enum logic [1:0] {
    SHAPE_LINE  = 2'd0,
    SHAPE_ARC   = 2'd1,
    SHAPE_QUAD  = 2'd2,
    SHAPE_CUBIC = 2'd3
  } shape_e;

  typedef enum logic [2:0] {
    REG_SHAPE  = 3'd0,
    REG_CP0    = 3'd1,
    REG_CP1    = 3'd2,
    REG_CP2    = 3'd3,
    REG_CP3    = 3'd4,
    REG_RADIUS = 3'd5,
    REG_START  = 3'd6,
    REG_END    = 3'd7
  } reg_e;

  typedef struct packed {
    shape_e             shape;
    logic [3:0][63:0]   cp;
    logic [31:0]        radius;
    logic signed [31:0] ang_start;
    logic signed [31:0] ang_end;
  } cfg_t;

  typedef struct packed {
    shape_e      shape;
    logic [16:0] t;
    logic [16:0] u;
  } item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/pcp_fifo.sv =====
// Small flip-flop queue with first-word-fall-through head.
module pcp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/pcp_front.sv =====
// Front end: clamps the curve parameter, forms 1 - t and tags the curve kind.
module pcp_front (
  input  logic [16:0]     t_i,
  input  pcp_pkg::shape_e shape_i,
  output pcp_pkg::item_t  item_o
);
  import pcp_pkg::*;

  logic [16:0] t_clamped;

  // anything above one counts as one
  assign t_clamped    = (t_i > QOne) ? QOne : t_i;
  assign item_o.t     = t_clamped;
  assign item_o.u     = QOne - t_clamped;
  assign item_o.shape = shape_i;

endmodule

// ===== hw/rtl/pcp_back.sv =====
// Back end: weight and angle pipeline, CORDIC stages and final blend.
module pcp_back #(
  parameter int unsigned CordicStages = pcp_pkg::CordicStagesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            in_valid_i,
  input  pcp_pkg::item_t  item_i,
  input  pcp_pkg::cfg_t   cfg_i,
  output logic            out_valid_o,
  output pcp_pkg::point_t point_o
);
  import pcp_pkg::*;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } rot_t;

  typedef struct packed {
    shape_e             shape;
    logic [1:0]         quad;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } side_t;

  // stage 1: first products
  logic               v1_q;
  shape_e             sh1_q;
  logic [16:0]        t1_q, u1_q;
  logic [32:0]        uu1_q, ut1_q, tt1_q;
  logic signed [49:0] ps1_q, pe1_q;

  // stage 2: cubic products, quadratic weights, lifted angle
  logic               v2_q;
  shape_e             sh2_q;
  logic [16:0]        t2_q, u2_q;
  logic [49:0]        u3_2_q, uut2_q, utt2_q, t3_2_q;
  logic [16:0]        wq0_2_q, wq1_2_q, wq2_2_q;
  logic [32:0]        ang2_q;
  logic signed [51:0] ang_sum;

  // stage 3: final weights, quotient product
  logic               v3_q;
  shape_e             sh3_q;
  logic [3:0][16:0]   w3_q, w3_d;
  logic [32:0]        nm3_q, ang3_q;

  // stage 4: weighted coordinates, degree remainder
  logic               v4_q;
  shape_e             sh4_q;
  logic signed [3:0][49:0] px4_q, py4_q, px4_d, py4_d;
  logic [22:0]        rem4_q;
  logic [1:0]         quad4_q;
  logic [10:0]        quo;

  // stage 5 onward: CORDIC levels
  logic               lv_q   [CordicStages+1];
  rot_t               rot_q  [CordicStages+1];
  side_t              side_q [CordicStages+1];
  logic signed [67:0] bsum_x, bsum_y;

  // final stages
  logic               vf1_q;
  side_t              sidef_q;
  logic signed [65:0] prx_q, pry_q;
  logic signed [32:0] cos_v, sin_v;
  logic               vf2_q;
  point_t             pt_q, pt_d;
  logic signed [67:0] ax, ay;

  // ---------------- stage 1
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sh1_q <= item_i.shape;
      t1_q  <= item_i.t;
      u1_q  <= item_i.u;
      uu1_q <= 33'(item_i.u) * 33'(item_i.u);
      ut1_q <= 33'(item_i.u) * 33'(item_i.t);
      tt1_q <= 33'(item_i.t) * 33'(item_i.t);
      ps1_q <= 50'(cfg_i.ang_start) * 50'(signed'({1'b0, item_i.u}));
      pe1_q <= 50'(cfg_i.ang_end) * 50'(signed'({1'b0, item_i.t}));
    end
  end

  // ---------------- stage 2
  assign ang_sum = ((52'(ps1_q) + 52'(pe1_q) + 52'sd32768) >>> 16) + AngleLift;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sh2_q   <= sh1_q;
      t2_q    <= t1_q;
      u2_q    <= u1_q;
      u3_2_q  <= 50'(uu1_q) * 50'(u1_q);
      uut2_q  <= 50'(uu1_q) * 50'(t1_q);
      utt2_q  <= 50'(tt1_q) * 50'(u1_q);
      t3_2_q  <= 50'(tt1_q) * 50'(t1_q);
      wq0_2_q <= 17'((35'(uu1_q) + 35'd32768) >> 16);
      wq1_2_q <= 17'(((35'(ut1_q) << 1) + 35'd32768) >> 16);
      wq2_2_q <= 17'((35'(tt1_q) + 35'd32768) >> 16);
      ang2_q  <= 33'(ang_sum);
    end
  end

  // ---------------- stage 3
  always_comb begin
    w3_d = '0;
    case (sh2_q)
      SHAPE_LINE: begin
        w3_d[0] = u2_q;
        w3_d[1] = t2_q;
      end
      SHAPE_QUAD: begin
        w3_d[0] = wq0_2_q;
        w3_d[1] = wq1_2_q;
        w3_d[2] = wq2_2_q;
      end
      SHAPE_CUBIC: begin
        w3_d[0] = 17'((52'(u3_2_q) + 52'd2147483648) >> 32);
        w3_d[1] = 17'((52'(uut2_q) + (52'(uut2_q) << 1) + 52'd2147483648) >> 32);
        w3_d[2] = 17'((52'(utt2_q) + (52'(utt2_q) << 1) + 52'd2147483648) >> 32);
        w3_d[3] = 17'((52'(t3_2_q) + 52'd2147483648) >> 32);
      end
      default: w3_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sh3_q  <= sh2_q;
      w3_q   <= w3_d;
      // quarter turns are 45 * 2^17: divide the upper bits by 45
      nm3_q  <= 33'(ang2_q[32:17]) * Recip45;
      ang3_q <= ang2_q;
    end
  end

  // ---------------- stage 4
  assign quo = nm3_q[32:22];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px4_d[k] = 50'(signed'({1'b0, w3_q[k]})) * 50'(signed'(cfg_i.cp[k][63:32]));
      py4_d[k] = 50'(signed'({1'b0, w3_q[k]})) * 50'(signed'(cfg_i.cp[k][31:0]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sh4_q   <= sh3_q;
      px4_q   <= px4_d;
      py4_q   <= py4_d;
      rem4_q  <= 23'(ang3_q - 33'(quo) * Deg90);
      quad4_q <= quo[1:0];
    end
  end

  // ---------------- stage 5: Bezier sums, radians, CORDIC seed
  always_comb begin
    bsum_x = 68'sd32768;
    bsum_y = 68'sd32768;
    // element selects are unsigned: sign-extend each product explicitly
    for (int k = 0; k < 4; k++) begin
      bsum_x = bsum_x + 68'(signed'(px4_q[k]));
      bsum_y = bsum_y + 68'(signed'(py4_q[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rot_q[0].x <= CordicGain;
      rot_q[0].y <= '0;
      rot_q[0].z <= 33'((58'(rem4_q) * Deg2Rad + 58'd33554432) >> 26);
      side_q[0].shape <= sh4_q;
      side_q[0].quad  <= quad4_q;
      side_q[0].bx    <= sat32(bsum_x >>> 16);
      side_q[0].by    <= sat32(bsum_y >>> 16);
    end
  end

  // ---------------- CORDIC rotation stages
  for (genvar i = 0; i < CordicStages; i++) begin : g_rot
    rot_t             nx;
    logic signed [32:0] dx, dy, da;

    assign dx = rot_q[i].y >>> i;
    assign dy = rot_q[i].x >>> i;
    assign da = signed'(33'(atan_q30(5'(i))));

    always_comb begin
      if (!rot_q[i].z[32]) begin
        nx.x = rot_q[i].x - dx;
        nx.y = rot_q[i].y + dy;
        nx.z = rot_q[i].z - da;
      end else begin
        nx.x = rot_q[i].x + dx;
        nx.y = rot_q[i].y - dy;
        nx.z = rot_q[i].z + da;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rot_q[i+1]  <= nx;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // ---------------- final stage 1: quadrant and radius products
  always_comb begin
    case (side_q[CordicStages].quad)
      2'd0: begin
        cos_v = rot_q[CordicStages].x;
        sin_v = rot_q[CordicStages].y;
      end
      2'd1: begin
        cos_v = -rot_q[CordicStages].y;
        sin_v = rot_q[CordicStages].x;
      end
      2'd2: begin
        cos_v = -rot_q[CordicStages].x;
        sin_v = -rot_q[CordicStages].y;
      end
      default: begin
        cos_v = rot_q[CordicStages].y;
        sin_v = -rot_q[CordicStages].x;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sidef_q <= side_q[CordicStages];
      prx_q   <= 66'(signed'({1'b0, cfg_i.radius})) * 66'(cos_v);
      pry_q   <= 66'(signed'({1'b0, cfg_i.radius})) * 66'(sin_v);
    end
  end

  // ---------------- final stage 2: centre offset, saturation, select
  assign ax = 68'(signed'(cfg_i.cp[0][63:32])) + ((68'(prx_q) + 68'sd536870912) >>> 30);
  assign ay = 68'(signed'(cfg_i.cp[0][31:0])) + ((68'(pry_q) + 68'sd536870912) >>> 30);

  always_comb begin
    if (sidef_q.shape == SHAPE_ARC) begin
      pt_d.x = sat32(ax);
      pt_d.y = sat32(ay);
    end else begin
      pt_d.x = sidef_q.bx;
      pt_d.y = sidef_q.by;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pt_q <= pt_d;
    end
  end

  // ---------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
      for (int k = 0; k <= CordicStages; k++) begin
        lv_q[k] <= 1'b0;
      end
    end else if (adv_i) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      lv_q[0] <= v4_q;
      for (int k = 1; k <= CordicStages; k++) begin
        lv_q[k] <= lv_q[k-1];
      end
      vf1_q <= lv_q[CordicStages];
      vf2_q <= vf1_q;
    end
  end

  assign out_valid_o = vf2_q;
  assign point_o     = pt_q;

endmodule

// ===== hw/rtl/parametric_curve_point_top.sv =====
// Top level of the parametric curve point generator.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------
//   input    | push / full               | t_param_i (17b, Q1.16)
//   result   | empty / pop               | tip_x_o, tip_y_o (32b, Q16.16)
//   config   | cfg_we_i (no wait)        | cfg_idx_i (3b), cfg_data_i (64b)
//
// One word accepted and one point delivered per cycle when neither side stalls.
// Each word passes through the word queue between ends, then the back pipeline:
// the product and weight stages, the CORDIC seed and rotation stages, and the
// final stages. Reset clears the configuration, queue pointers and valid chain;
// no clearing pass. When the result queue is full the whole back pipeline holds,
// and the front keeps accepting until its queue fills.
module parametric_curve_point_top #(
  parameter int unsigned CordicStages = pcp_pkg::CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [16:0]        t_param_i,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] tip_x_o,
  output logic signed [31:0] tip_y_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);
  import pcp_pkg::*;

  cfg_t   cfg_q;
  item_t  front_item, mid_item;
  logic   mid_empty, out_full, adv, back_valid;
  point_t back_point, out_point;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_SHAPE:  cfg_q.shape     <= shape_e'(cfg_data_i[1:0]);
        REG_CP0:    cfg_q.cp[0]     <= cfg_data_i;
        REG_CP1:    cfg_q.cp[1]     <= cfg_data_i;
        REG_CP2:    cfg_q.cp[2]     <= cfg_data_i;
        REG_CP3:    cfg_q.cp[3]     <= cfg_data_i;
        REG_RADIUS: cfg_q.radius    <= cfg_data_i[31:0];
        REG_START:  cfg_q.ang_start <= signed'(cfg_data_i[31:0]);
        REG_END:    cfg_q.ang_end   <= signed'(cfg_data_i[31:0]);
        default:    cfg_q           <= cfg_q;
      endcase
    end
  end

  pcp_front u_front (
    .t_i     (t_param_i),
    .shape_i (cfg_q.shape),
    .item_o  (front_item)
  );

  pcp_fifo #(
    .Width ($bits(item_t)),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (adv),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  // advance the back pipeline whenever the result queue has room
  assign adv = !out_full;

  pcp_back #(
    .CordicStages (CordicStages)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (!mid_empty),
    .item_i      (mid_item),
    .cfg_i       (cfg_q),
    .out_valid_o (back_valid),
    .point_o     (back_point)
  );

  pcp_fifo #(
    .Width ($bits(point_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv && back_valid),
    .data_i  (back_point),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_point),
    .empty_o (empty)
  );

  assign tip_x_o = out_point.x;
  assign tip_y_o = out_point.y;

endmodule

// ===== hw/rtl/pcp_checker.sv =====
// Port-level checks of the curve point block and their binding.
module pcp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input logic signed [31:0] tip_x_o,
  input logic signed [31:0] tip_y_o
);

  // a waiting result word stays until taken
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result word dropped before pop");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(tip_x_o) && $stable(tip_y_o)))
    else $error("result word changed while stalled");

  // right after reset the result queue is empty and the input queue is not full
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> (empty && !full))
    else $error("queues not clear after reset");

endmodule

bind parametric_curve_point_top pcp_checker u_pcp_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .full    (full),
  .pop     (pop),
  .empty   (empty),
  .tip_x_o (tip_x_o),
  .tip_y_o (tip_y_o)
);

// ===== sim/tb_parametric_curve_point_top.sv =====
// Testbench for the parametric curve point generator: random and directed t words.
`timescale 1ns / 1ps

module tb_parametric_curve_point_top;
  import pcp_pkg::*;

  localparam int unsigned Stages  = CordicStagesDef;
  localparam int unsigned Latency = Stages + 7 + MidDepth + OutDepth + 8;
  localparam longint CycleLimit   = 400000;

  localparam longint QOneL   = 65536;
  localparam longint Deg360L = 23592960;
  localparam longint Deg90L  = 5898240;
  localparam longint GainL   = 652032874;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [16:0] t_param_i = '0;
  logic pop = 1'b0;
  logic empty;
  logic signed [31:0] tip_x_o, tip_y_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  parametric_curve_point_top u_top (.*);

  always #5 clk_i = ~clk_i;

  // Shadow configuration
  shape_e      shape_sh;
  logic [63:0] cp_sh [4];
  logic [31:0] radius_sh, start_sh, end_sh;

  logic [16:0] t_pending [$];
  point_t      points_due [$];
  int          mismatches = 0;
  int          points_seen = 0;
  int          words_sent = 0;
  longint      cycles = 0;
  bit          hold_off = 1'b0;
  bit          in_took = 1'b0;
  int          shape_hits [4];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint coord(int k, bit is_y);
    return is_y ? longint'($signed(cp_sh[k][31:0])) : longint'($signed(cp_sh[k][63:32]));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint tab [32] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    return tab[i];
  endfunction

  function automatic point_t curve_point(logic [16:0] t_raw);
    longint t, u, w [4], px, py, th, r, q, rem, z, x, y, c, s, dx, dy, ax, ay;
    int n;
    logic [127:0] zw;
    point_t p;
    t = (t_raw > QOne) ? QOneL : longint'(t_raw);
    u = QOneL - t;
    n = 0;
    case (shape_sh)
      SHAPE_LINE: begin
        w[0] = u; w[1] = t; n = 2;
      end
      SHAPE_QUAD: begin
        w[0] = (u * u + 32768) >>> 16;
        w[1] = (2 * u * t + 32768) >>> 16;
        w[2] = (t * t + 32768) >>> 16;
        n = 3;
      end
      SHAPE_CUBIC: begin
        w[0] = (u * u * u + 64'sd2147483648) >>> 32;
        w[1] = (3 * u * u * t + 64'sd2147483648) >>> 32;
        w[2] = (3 * u * t * t + 64'sd2147483648) >>> 32;
        w[3] = (t * t * t + 64'sd2147483648) >>> 32;
        n = 4;
      end
      default: n = 0;
    endcase
    if (n != 0) begin
      ax = 0; ay = 0;
      for (int k = 0; k < n; k++) begin
        ax += w[k] * coord(k, 0);
        ay += w[k] * coord(k, 1);
      end
      px = round_shr(ax, 16);
      py = round_shr(ay, 16);
    end else begin
      th = round_shr(longint'($signed(start_sh)) * u + longint'($signed(end_sh)) * t, 16);
      r = th % Deg360L;
      if (r < 0) r += Deg360L;
      q = r / Deg90L;
      rem = r - q * Deg90L;
      zw = (128'(rem) * 128'd19190098069 + (128'd1 << 25)) >> 26;
      z = longint'(zw[63:0]);
      x = GainL; y = 0;
      for (int i = 0; i < ((Stages > 32) ? 32 : Stages); i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_entry(i);
        end else begin
          x += dx; y -= dy; z += atan_entry(i);
        end
      end
      case (q)
        0: begin c = x; s = y; end
        1: begin c = -y; s = x; end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      px = coord(0, 0) + round_shr(longint'(radius_sh) * c, 30);
      py = coord(0, 1) + round_shr(longint'(radius_sh) * s, 30);
    end
    p.x = 32'(clamp32(px));
    p.y = 32'(clamp32(py));
    return p;
  endfunction

  task automatic write_reg(reg_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SHAPE:  shape_sh = shape_e'(val[1:0]);
      REG_CP0:    cp_sh[0] = val;
      REG_CP1:    cp_sh[1] = val;
      REG_CP2:    cp_sh[2] = val;
      REG_CP3:    cp_sh[3] = val;
      REG_RADIUS: radius_sh = val[31:0];
      REG_START:  start_sh = val[31:0];
      default:    end_sh = val[31:0];
    endcase
  endtask

  function automatic logic [63:0] rand_point(int style);
    logic [31:0] a, b;
    case (style)
      0: begin a = 32'h7fffffff; b = 32'h80000000; end
      1: begin a = 32'h80000000; b = 32'h7fffffff; end
      2: begin a = {$urandom}; b = {$urandom}; end
      default: begin
        a = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
        b = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
      end
    endcase
    return {a, b};
  endfunction

  // Wait for the block to drain, then give it its latency to settle
  task automatic drain();
    wait (t_pending.size() == 0 && points_due.size() == 0);
    repeat (Latency) @(negedge clk_i);
  endtask

  task automatic load_setting(shape_e sk, int style);
    write_reg(REG_SHAPE, 64'(sk));
    for (int k = 0; k < 4; k++) write_reg(reg_e'(REG_CP0 + k), rand_point(style));
    case (style)
      0: write_reg(REG_RADIUS, 64'hffffffff);
      1: write_reg(REG_RADIUS, 64'h0);
      default: write_reg(REG_RADIUS, 64'($urandom_range(0, 300 << 16)));
    endcase
    case (style)
      0: begin write_reg(REG_START, 64'h7fffffff); write_reg(REG_END, 64'hffffffff80000000); end
      1: begin write_reg(REG_START, 64'hffffffff80000000); write_reg(REG_END, 64'h7fffffff); end
      default: begin
        write_reg(REG_START, 64'($signed($urandom)));
        write_reg(REG_END, 64'($signed($urandom_range(0, 720 << 16)) - (360 << 16)));
      end
    endcase
  endtask

  function automatic logic [16:0] rand_t();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 17'($urandom);
    if (sel == 1) return QOne;
    if (sel == 2) return 17'd0;
    return 17'($urandom_range(0, 65536));
  endfunction

  // Record each accepted word at the edge that takes it
  always @(posedge clk_i) begin
    in_took = 1'b0;
    if (rst_ni && push && !full) begin
      in_took = 1'b1;
      points_due.push_back(curve_point(t_param_i));
      shape_hits[shape_sh]++;
      words_sent++;
      void'(t_pending.pop_front());
    end
  end

  // Driver: bursts and gaps; push stays high across back-to-back words
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && !in_took) begin
        // hold the offered word
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (t_pending.size() != 0) begin
        push <= 1'b1;
        t_param_i <= t_pending[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
        end else if (--burst_left == 0 && $urandom_range(0, 2) == 0) begin
          gap_left = $urandom_range(1, 6);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off counted in its own process
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase = (stall_phase + 1) % 23;
    if (hold_off) begin
      pop <= 1'b0;
    end else if (stall_phase < 8) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    wait (rst_ni);
    repeat (500) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // Monitor
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni) begin
      cycles++;
      if (pop && !empty) begin
        points_seen++;
        if (points_due.size() == 0) begin
          $error("point with no word pending: x=%0d y=%0d", tip_x_o, tip_y_o);
          mismatches++;
        end else begin
          want = points_due.pop_front();
          if (tip_x_o !== want.x) begin
            $error("tip_x expected %0d actual %0d", want.x, tip_x_o);
            mismatches++;
          end
          if (tip_y_o !== want.y) begin
            $error("tip_y expected %0d actual %0d", want.y, tip_y_o);
            mismatches++;
          end
        end
      end
      if (cycles > CycleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    shape_sh = SHAPE_LINE;
    for (int k = 0; k < 4; k++) cp_sh[k] = '0;
    radius_sh = '0; start_sh = '0; end_sh = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: each shape at corner settings with t extremes and beyond one
    for (int sk = 0; sk < 4; sk++) begin
      load_setting(shape_e'(sk), sk % 2);
      t_pending.push_back(17'd0);
      t_pending.push_back(QOne);
      t_pending.push_back(17'h1ffff);
      t_pending.push_back(17'd32768);
      t_pending.push_back(17'h10001);
      drain();
    end
    // Sender pause: wait for every point before continuing
    drain();

    for (int ph = 0; ph < 24; ph++) begin
      load_setting(shape_e'(ph % 4), (ph < 4) ? (ph % 2) : $urandom_range(2, 3));
      for (int i = 0; i < 50; i++) t_pending.push_back(rand_t());
      drain();
    end

    $display("Sent %0d words, checked %0d points (line %0d, arc %0d, quad %0d, cubic %0d).",
             words_sent, points_seen, shape_hits[0], shape_hits[1], shape_hits[2],
             shape_hits[3]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
